[rtl/assert_macros.svh]
// Assertion helpers, clocked on aclk and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FPFD_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

`define FPFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/fpfd_pkg.sv]
package fpfd_pkg;

    localparam int FRAME_BYTES  = 42;
    localparam int NUM_CHANNELS = 15;
    localparam int NUM_CARS     = 2;
    localparam int SUM_BYTES    = 41;
    localparam int NUM_PROBES   = 4;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [7:0] HDR_BYTE   = 8'hAA;
    localparam logic [7:0] LEN_CODE   = 8'h2A;
    localparam logic [7:0] TYPE_MASK  = 8'h07;
    localparam logic [7:0] STATE_MASK = 8'h38;
    localparam logic [4:0] COUNT_MAX  = 5'd31;

    localparam logic REG_CHANNEL_MAP = 1'b0;
    localparam logic REG_TIMEOUT     = 1'b1;

    typedef enum logic [3:0] {
        EV_BAD_HEADER   = 4'd0,
        EV_BAD_LENGTH   = 4'd1,
        EV_BAD_CHECKSUM = 4'd2,
        EV_NOT_FIRE     = 4'd3,
        EV_BUS_OPEN     = 4'd4,
        EV_BUS_SHORT    = 4'd5,
        EV_BUS_OTHER    = 4'd6,
        EV_PROBES       = 4'd7,
        EV_TIMEOUT      = 4'd8
    } event_t;

    typedef enum logic [1:0] {
        ALM_NEVER   = 2'd0,
        ALM_ACTIVE  = 2'd1,
        ALM_CLEARED = 2'd2
    } alarm_t;

    typedef struct packed {
        event_t        event_res;
        logic          event_car;
        logic [11:0]   probe_types;
        logic [11:0]   probe_states;
        logic [3:0]    alarm_probes;
        alarm_t        alarm_flag;
        logic [NUM_CHANNELS-1:0] channel_alarms;
        logic          last;
    } result_t;

endpackage

[rtl/fire_probe_frame_decoder_top.sv]
// Fire-detector frame decoder, cars A and B.
// Input channel (s_*): one item per frame byte (s_func 0) or one-second
// tick (s_func 1). s_frame_start marks byte 0 of a 42-byte frame.
// Result channel (m_*): one item on the last byte of each frame, up to two
// items (one per silent car) on a tick; m_last marks the final result of
// an input item.
// Config port: cfg_we/cfg_index/cfg_wdata, index 0 probe channel map,
// index 1 timeout seconds; write only while no item is in flight.
// Throughput: one input item per cycle while the result queue has room for two
// results; each item is decoded from the input register into a 4-entry result queue.
// An item is held in the input register and its results are written to
// the result queue, which drives m_valid and the m_* outputs.
// s_ready drops while an item waits in the input register and the queue
// holds more than two results, i.e. when the receiver stalls the queue
// fills and the input side then stalls.
// Reset (aresetn low, synchronous) closes any open frame, clears alarm
// flag, channel mask, silence counters and the result queue, and loads
// channel map 0 and timeout 15.
module fire_probe_frame_decoder_top
    import fpfd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_func,
    input  logic                    s_car,
    input  logic [7:0]              s_data_byte,
    input  logic                    s_frame_start,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [3:0]              m_event_res,
    output logic                    m_event_car,
    output logic [11:0]             m_probe_types,
    output logic [11:0]             m_probe_states,
    output logic [3:0]              m_alarm_probes,
    output logic [1:0]              m_alarm_flag,
    output logic [NUM_CHANNELS-1:0] m_channel_alarms,
    output logic                    m_last,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [15:0]             cfg_wdata
);

    `include "assert_macros.svh"

    // config
    logic [15:0] chan_map_reg;
    logic [4:0]  timeout_reg;

    // input register
    logic       in_valid_reg;
    logic       in_func_reg, in_car_reg, in_fs_reg;
    logic [7:0] in_byte_reg;

    // frame state
    logic [5:0] byte_idx_reg, byte_idx_next;
    logic       frame_active_reg, frame_active_next;
    logic       frame_car_reg, frame_car_next;
    logic [7:0] sum_reg, sum_next;
    logic       hdr_good_reg, hdr_good_next;
    logic       len_good_reg, len_good_next;
    logic [7:0] msg_type_reg, msg_type_next;
    logic [7:0] bus_code_reg, bus_code_next;
    logic [7:0] probe_reg [NUM_PROBES];
    logic       probe_we;
    logic [1:0] probe_wa;
    alarm_t     alarm_reg, alarm_next;
    logic [NUM_CHANNELS-1:0] mask_reg, mask_next;
    logic [4:0] silence_reg [NUM_CARS];
    logic [4:0] silence_next [NUM_CARS];

    // result queue
    result_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     cnt_reg;
    result_t              res0, res1;
    logic [1:0]           n_push;
    logic                 proc, pop, finish;

    assign proc    = in_valid_reg && (cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign s_ready = !in_valid_reg || proc;
    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid && m_ready;

    always_comb begin
        logic       eff_active, eff_hg, eff_lg, eff_car;
        logic [5:0] idx, idx_m6;
        logic [7:0] eff_sum, b;
        logic [2:0] t, s, tc, sc;
        logic [3:0] ch;
        logic [11:0] types, states;
        logic [3:0] alarms;
        logic [NUM_CHANNELS-1:0] set_mask;
        event_t     ev;

        byte_idx_next     = byte_idx_reg;
        frame_active_next = frame_active_reg;
        frame_car_next    = frame_car_reg;
        sum_next          = sum_reg;
        hdr_good_next     = hdr_good_reg;
        len_good_next     = len_good_reg;
        msg_type_next     = msg_type_reg;
        bus_code_next     = bus_code_reg;
        alarm_next        = alarm_reg;
        mask_next         = mask_reg;
        for (int c = 0; c < NUM_CARS; c++) begin
            silence_next[c] = silence_reg[c];
        end
        probe_we = 1'b0;
        probe_wa = '0;
        finish   = 1'b0;
        res0     = '0;
        res1     = '0;
        n_push   = 2'd0;
        types    = '0;
        states   = '0;
        alarms   = '0;
        set_mask = '0;
        ev       = EV_PROBES;
        b        = in_byte_reg;
        t        = '0;
        s        = '0;
        tc       = '0;
        sc       = '0;
        ch       = '0;

        eff_active = in_fs_reg ? (32'(in_car_reg) < NUM_CARS) : frame_active_reg;
        eff_car    = in_fs_reg ? in_car_reg : frame_car_reg;
        idx        = in_fs_reg ? 6'd0 : byte_idx_reg;
        eff_sum    = in_fs_reg ? 8'd0 : sum_reg;
        eff_hg     = in_fs_reg ? 1'b1 : hdr_good_reg;
        eff_lg     = in_fs_reg ? 1'b1 : len_good_reg;
        idx_m6     = idx - 6'd6;

        if (in_func_reg) begin
            for (int c = 0; c < NUM_CARS; c++) begin
                if (silence_reg[c] > timeout_reg) begin
                    if (n_push == 2'd0) begin
                        res0.event_res      = EV_TIMEOUT;
                        res0.event_car      = 1'(c);
                        res0.alarm_flag     = alarm_reg;
                        res0.channel_alarms = mask_reg;
                    end else begin
                        res1.event_res      = EV_TIMEOUT;
                        res1.event_car      = 1'(c);
                        res1.alarm_flag     = alarm_reg;
                        res1.channel_alarms = mask_reg;
                    end
                    n_push = n_push + 2'd1;
                    silence_next[c] = 5'd0;
                end
                if (silence_next[c] < COUNT_MAX) begin
                    silence_next[c] = silence_next[c] + 5'd1;
                end
            end
            if (n_push == 2'd1) res0.last = 1'b1;
            if (n_push == 2'd2) res1.last = 1'b1;
        end else begin
            frame_active_next = eff_active;
            if (in_fs_reg) begin
                frame_car_next = in_car_reg;
                byte_idx_next  = 6'd0;
                sum_next       = 8'd0;
                hdr_good_next  = 1'b1;
                len_good_next  = 1'b1;
            end
            if (eff_active) begin
                if ((idx == 6'd0 || idx == 6'd1) && b != HDR_BYTE) hdr_good_next = 1'b0;
                if (idx == 6'd2 && b != LEN_CODE) len_good_next = 1'b0;
                if (idx == 6'd3 && b != 8'd0) len_good_next = 1'b0;
                if (idx == 6'd4) msg_type_next = b;
                if (idx == 6'd5) bus_code_next = b;
                if (idx >= 6'd6 && idx <= 6'd9) begin
                    probe_we = 1'b1;
                    probe_wa = idx_m6[1:0];
                end
                if (idx < 6'(SUM_BYTES)) sum_next = eff_sum + b;
                else sum_next = eff_sum;

                if (idx >= 6'(FRAME_BYTES - 1)) begin
                    finish            = 1'b1;
                    frame_active_next = 1'b0;
                    byte_idx_next     = 6'd0;
                    if (!eff_hg) begin
                        ev = EV_BAD_HEADER;
                    end else begin
                        silence_next[eff_car] = 5'd0;
                        if (!eff_lg) ev = EV_BAD_LENGTH;
                        else if (eff_sum != b) ev = EV_BAD_CHECKSUM;
                        else if (msg_type_reg != 8'd1) ev = EV_NOT_FIRE;
                        else if (bus_code_reg == 8'd1) ev = EV_BUS_OPEN;
                        else if (bus_code_reg == 8'd2) ev = EV_BUS_SHORT;
                        else if (bus_code_reg != 8'd0) ev = EV_BUS_OTHER;
                        else ev = EV_PROBES;
                    end
                    if (ev == EV_PROBES) begin
                        for (int p = 0; p < NUM_PROBES; p++) begin
                            t = 3'(probe_reg[p] & TYPE_MASK);
                            s = 3'((probe_reg[p] & STATE_MASK) >> 3);
                            case (t)
                                3'd0:       tc = 3'd0;
                                3'd1, 3'd5: tc = 3'd1;
                                3'd2:       tc = 3'd2;
                                3'd3, 3'd4: tc = 3'd3;
                                default:    tc = 3'd4;
                            endcase
                            if (t == 3'd0) sc = 3'd6;
                            else if (s <= 3'd4) sc = s;
                            else sc = 3'd5;
                            if (sc == 3'd4) begin
                                alarms[p] = 1'b1;
                                ch = chan_map_reg[4*p +: 4];
                                for (int j = 0; j < NUM_CHANNELS; j++) begin
                                    if (32'(ch) == j + 1) set_mask[j] = 1'b1;
                                end
                            end
                            types[3*p +: 3]  = tc;
                            states[3*p +: 3] = sc;
                        end
                        if (alarms != 4'd0) begin
                            alarm_next = ALM_ACTIVE;
                            mask_next  = mask_reg | set_mask;
                        end else begin
                            mask_next = '0;
                            if (alarm_reg == ALM_ACTIVE) alarm_next = ALM_CLEARED;
                        end
                    end
                    res0.event_res      = ev;
                    res0.event_car      = eff_car;
                    res0.probe_types    = types;
                    res0.probe_states   = states;
                    res0.alarm_probes   = alarms;
                    res0.alarm_flag     = alarm_next;
                    res0.channel_alarms = mask_next;
                    res0.last           = 1'b1;
                    n_push              = 2'd1;
                end else begin
                    byte_idx_next = idx + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_map_reg <= 16'd0;
            timeout_reg  <= 5'd15;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CHANNEL_MAP: chan_map_reg <= cfg_wdata;
                REG_TIMEOUT:     timeout_reg  <= cfg_wdata[4:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_car_reg  <= s_car;
            in_byte_reg <= s_data_byte;
            in_fs_reg   <= s_frame_start;
        end
        if (proc && probe_we) begin
            probe_reg[probe_wa] <= in_byte_reg;
        end
        if (proc && n_push != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (proc && n_push == 2'd2) begin
            fifo_mem[wr_ptr_reg + FIFO_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_idx_reg     <= '0;
            frame_active_reg <= 1'b0;
            frame_car_reg    <= 1'b0;
            sum_reg          <= '0;
            hdr_good_reg     <= 1'b0;
            len_good_reg     <= 1'b0;
            msg_type_reg     <= '0;
            bus_code_reg     <= '0;
            alarm_reg        <= ALM_NEVER;
            mask_reg         <= '0;
            for (int c = 0; c < NUM_CARS; c++) begin
                silence_reg[c] <= '0;
            end
        end else if (proc) begin
            byte_idx_reg     <= byte_idx_next;
            frame_active_reg <= frame_active_next;
            frame_car_reg    <= frame_car_next;
            sum_reg          <= sum_next;
            hdr_good_reg     <= hdr_good_next;
            len_good_reg     <= len_good_next;
            msg_type_reg     <= msg_type_next;
            bus_code_reg     <= bus_code_next;
            alarm_reg        <= alarm_next;
            mask_reg         <= mask_next;
            for (int c = 0; c < NUM_CARS; c++) begin
                silence_reg[c] <= silence_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (proc) wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(n_push);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            cnt_reg <= cnt_reg + (FIFO_AW+1)'(proc ? n_push : 2'd0)
                     - (FIFO_AW+1)'(pop);
        end
    end

    assign m_event_res      = fifo_mem[rd_ptr_reg].event_res;
    assign m_event_car      = fifo_mem[rd_ptr_reg].event_car;
    assign m_probe_types    = fifo_mem[rd_ptr_reg].probe_types;
    assign m_probe_states   = fifo_mem[rd_ptr_reg].probe_states;
    assign m_alarm_probes   = fifo_mem[rd_ptr_reg].alarm_probes;
    assign m_alarm_flag     = fifo_mem[rd_ptr_reg].alarm_flag;
    assign m_channel_alarms = fifo_mem[rd_ptr_reg].channel_alarms;
    assign m_last           = fifo_mem[rd_ptr_reg].last;

    `FPFD_ASSERT(a_queue_bound, cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")
    `FPFD_ASSERT_NEXT(a_frame_closes, proc && finish, !frame_active_reg, "frame left open")
    `FPFD_ASSERT(a_frame_last, !m_valid || m_event_res == EV_TIMEOUT || m_last, "frame result not last")
    `FPFD_ASSERT_NEXT(a_no_push_full, cnt_reg > (FIFO_AW+1)'(FIFO_DEPTH - 2) && !pop, cnt_reg == $past(cnt_reg), "push into full queue")

endmodule

[bench/tb_fire_probe_frame_decoder_top.sv]
module tb_fire_probe_frame_decoder_top
    import fpfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS    = 150;
    localparam int QUIET_ITEMS     = 100;
    localparam int WATCHDOG_CYCLES = 2000;

    localparam logic [7:0] FIRE_MSG  = 8'd1;
    localparam logic [7:0] BUS_OK    = 8'd0;
    localparam logic [7:0] BUS_OPEN  = 8'd1;
    localparam logic [7:0] BUS_SHORT = 8'd2;

    localparam logic [2:0] PT_ABSENT  = 3'd0;
    localparam logic [2:0] PT_SMOKE   = 3'd1;
    localparam logic [2:0] PT_HEAT    = 3'd2;
    localparam logic [2:0] PT_FLAME   = 3'd3;
    localparam logic [2:0] PT_UNKNOWN = 3'd4;
    localparam logic [2:0] PS_ALARM   = 3'd4;
    localparam logic [2:0] PS_UNKNOWN = 3'd5;
    localparam logic [2:0] PS_ABSENT  = 3'd6;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_func = 1'b0;
    logic                    s_car = 1'b0;
    logic [7:0]              s_data_byte = 8'h00;
    logic                    s_frame_start = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [3:0]              m_event_res;
    logic                    m_event_car;
    logic [11:0]             m_probe_types;
    logic [11:0]             m_probe_states;
    logic [3:0]              m_alarm_probes;
    logic [1:0]              m_alarm_flag;
    logic [NUM_CHANNELS-1:0] m_channel_alarms;
    logic                    m_last;
    logic                    cfg_we = 1'b0;
    logic                    cfg_index = 1'b0;
    logic [15:0]             cfg_wdata = 16'h0000;

    // shadow of the decoder
    logic [15:0]             map_reg = 16'h0000;
    logic [4:0]              timeout_reg = 5'd15;
    logic [5:0]              byte_pos = 6'd0;
    logic                    in_frame = 1'b0;
    logic                    frame_car_q = 1'b0;
    logic [7:0]              sum_acc = 8'h00;
    logic                    hdr_ok = 1'b0;
    logic                    len_ok = 1'b0;
    logic [7:0]              msg_type = 8'h00;
    logic [7:0]              bus_code = 8'h00;
    logic [7:0]              probe_raw [NUM_PROBES];
    alarm_t                  alarm_now = ALM_NEVER;
    logic [NUM_CHANNELS-1:0] chan_mask = '0;
    logic [4:0]              silence_secs [NUM_CARS] = '{default: 5'd0};

    result_t                 pending_events [$];
    result_t                 want;
    logic [7:0]              frame_buf [FRAME_BYTES];

    int                      items_sent = 0;
    int                      mismatches = 0;
    int                      idle_cycles = 0;
    logic                    src_idle_on = 1'b1;
    logic                    sink_stall_on = 1'b1;

    fire_probe_frame_decoder_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_car            (s_car),
        .s_data_byte      (s_data_byte),
        .s_frame_start    (s_frame_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_event_car      (m_event_car),
        .m_probe_types    (m_probe_types),
        .m_probe_states   (m_probe_states),
        .m_alarm_probes   (m_alarm_probes),
        .m_alarm_flag     (m_alarm_flag),
        .m_channel_alarms (m_channel_alarms),
        .m_last           (m_last),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    function automatic void push_event(event_t ev, logic car, logic [11:0] types,
                                       logic [11:0] states, logic [3:0] alarms,
                                       logic lst);
        result_t r;
        r.event_res      = ev;
        r.event_car      = car;
        r.probe_types    = types;
        r.probe_states   = states;
        r.alarm_probes   = alarms;
        r.alarm_flag     = alarm_now;
        r.channel_alarms = chan_mask;
        r.last           = lst;
        pending_events.push_back(r);
    endfunction

    function automatic void close_frame(logic [7:0] check);
        event_t     ev;
        logic [11:0] types;
        logic [11:0] states;
        logic [3:0] alarms;
        logic [7:0] raw;
        logic [2:0] t;
        logic [2:0] s;
        logic [2:0] tc;
        logic [2:0] sc;
        logic [3:0] ch;
        types  = '0;
        states = '0;
        alarms = '0;
        if (!hdr_ok) begin
            push_event(EV_BAD_HEADER, frame_car_q, '0, '0, '0, 1'b1);
        end else begin
            silence_secs[frame_car_q] = 5'd0;
            if (!len_ok) ev = EV_BAD_LENGTH;
            else if (sum_acc != check) ev = EV_BAD_CHECKSUM;
            else if (msg_type != FIRE_MSG) ev = EV_NOT_FIRE;
            else if (bus_code == BUS_OPEN) ev = EV_BUS_OPEN;
            else if (bus_code == BUS_SHORT) ev = EV_BUS_SHORT;
            else if (bus_code != BUS_OK) ev = EV_BUS_OTHER;
            else ev = EV_PROBES;
            if (ev != EV_PROBES) begin
                push_event(ev, frame_car_q, '0, '0, '0, 1'b1);
            end else begin
                for (int i = 0; i < NUM_PROBES; i++) begin
                    raw = probe_raw[i];
                    t   = 3'(raw & TYPE_MASK);
                    s   = 3'((raw & STATE_MASK) >> 3);
                    case (t)
                        3'd0:       tc = PT_ABSENT;
                        3'd1, 3'd5: tc = PT_SMOKE;
                        3'd2:       tc = PT_HEAT;
                        3'd3, 3'd4: tc = PT_FLAME;
                        default:    tc = PT_UNKNOWN;
                    endcase
                    if (t == 3'd0) sc = PS_ABSENT;
                    else if (s <= PS_ALARM) sc = s;
                    else sc = PS_UNKNOWN;
                    if (sc == PS_ALARM) begin
                        alarms[i] = 1'b1;
                        ch = map_reg[4*i +: 4];
                        if (ch != 4'd0 && ch <= NUM_CHANNELS) chan_mask[ch - 4'd1] = 1'b1;
                    end
                    types[3*i +: 3]  = tc;
                    states[3*i +: 3] = sc;
                end
                if (alarms != 4'd0) begin
                    alarm_now = ALM_ACTIVE;
                end else begin
                    chan_mask = '0;
                    if (alarm_now == ALM_ACTIVE) alarm_now = ALM_CLEARED;
                end
                push_event(EV_PROBES, frame_car_q, types, states, alarms, 1'b1);
            end
        end
    endfunction

    function automatic void predict_item(logic f, logic c, logic [7:0] d, logic fs);
        logic [5:0] idx;
        logic       hit [NUM_CARS];
        if (f) begin
            for (int k = 0; k < NUM_CARS; k++) begin
                hit[k] = silence_secs[k] > timeout_reg;
                if (hit[k]) silence_secs[k] = 5'd0;
                if (silence_secs[k] != COUNT_MAX) silence_secs[k]++;
            end
            if (hit[0]) push_event(EV_TIMEOUT, 1'b0, '0, '0, '0, !hit[1]);
            if (hit[1]) push_event(EV_TIMEOUT, 1'b1, '0, '0, '0, 1'b1);
        end else begin
            if (fs) begin
                in_frame    = 1'b1;
                frame_car_q = c;
                byte_pos    = 6'd0;
                sum_acc     = 8'h00;
                hdr_ok      = 1'b1;
                len_ok      = 1'b1;
            end
            if (in_frame) begin
                idx = byte_pos;
                case (idx)
                    6'd0, 6'd1: if (d != HDR_BYTE) hdr_ok = 1'b0;
                    6'd2: if (d != LEN_CODE) len_ok = 1'b0;
                    6'd3: if (d != 8'h00) len_ok = 1'b0;
                    6'd4: msg_type = d;
                    6'd5: bus_code = d;
                    6'd6, 6'd7, 6'd8, 6'd9: probe_raw[2'(idx - 6'd6)] = d;
                    default: ;
                endcase
                if (idx < SUM_BYTES) sum_acc = sum_acc + d;
                if (idx >= FRAME_BYTES - 1) begin
                    in_frame = 1'b0;
                    byte_pos = 6'd0;
                    close_frame(d);
                end else begin
                    byte_pos = idx + 6'd1;
                end
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val) report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_val));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                want = pending_events.pop_front();
                check_field("event_res", m_event_res, want.event_res);
                check_field("event_car", m_event_car, want.event_car);
                check_field("probe_types", m_probe_types, want.probe_types);
                check_field("probe_states", m_probe_states, want.probe_states);
                check_field("alarm_probes", m_alarm_probes, want.alarm_probes);
                check_field("alarm_flag", m_alarm_flag, want.alarm_flag);
                check_field("channel_alarms", m_channel_alarms, want.channel_alarms);
                check_field("last", m_last, want.last);
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= !(sink_stall_on && $urandom_range(99) < 13);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_item(input logic f, input logic c, input logic [7:0] d,
                             input logic fs);
        @(negedge aclk);
        while (src_idle_on && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= f;
        s_car         <= c;
        s_data_byte   <= d;
        s_frame_start <= fs;
        do @(posedge aclk); while (!s_ready);
        predict_item(f, c, d, fs);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(1'b1, 1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
    endtask

    task automatic wait_drained(input int settle);
        @(negedge aclk) s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_reg(input logic idx, input logic [15:0] val);
        wait_drained(4);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk) cfg_we <= 1'b0;
        if (idx == REG_CHANNEL_MAP) map_reg = val;
        else timeout_reg = val[4:0];
    endtask

    function automatic void build_frame(logic [7:0] msg, logic [7:0] bus);
        frame_buf[0] = HDR_BYTE;
        frame_buf[1] = HDR_BYTE;
        frame_buf[2] = LEN_CODE;
        frame_buf[3] = 8'h00;
        frame_buf[4] = msg;
        frame_buf[5] = bus;
        for (int i = 6; i < FRAME_BYTES; i++) frame_buf[i] = 8'($urandom);
    endfunction

    function automatic void set_probes(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2,
                                       logic [7:0] p3);
        frame_buf[6] = p0;
        frame_buf[7] = p1;
        frame_buf[8] = p2;
        frame_buf[9] = p3;
    endfunction

    function automatic void seal_frame();
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < SUM_BYTES; i++) acc = acc + frame_buf[i];
        frame_buf[FRAME_BYTES-1] = acc;
    endfunction

    // ticks may be slipped in between bytes; they must not disturb the frame
    task automatic send_frame(input logic c, input int nbytes, input int tick_pct);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(99) < tick_pct) send_tick();
            send_item(1'b0, (i == 0) ? c : 1'($urandom_range(1)), frame_buf[i], i == 0);
        end
    endtask

    task automatic rand_frame(input int nbytes, input int tick_pct);
        logic [7:0] msg;
        logic [7:0] bus;
        int         k;
        msg = ($urandom_range(9) == 0) ? 8'($urandom) : FIRE_MSG;
        k   = $urandom_range(99);
        bus = (k < 70) ? BUS_OK : (k < 80) ? BUS_OPEN : (k < 90) ? BUS_SHORT : 8'($urandom);
        build_frame(msg, bus);
        k = $urandom_range(99);
        if (k < 5) frame_buf[$urandom_range(1)] = 8'($urandom);
        else if (k < 10) frame_buf[$urandom_range(2, 3)] ^= 8'($urandom_range(1, 255));
        seal_frame();
        if (k >= 10 && k < 15) frame_buf[FRAME_BYTES-1] ^= 8'($urandom_range(1, 255));
        send_frame(1'($urandom_range(1)), nbytes, tick_pct);
    endtask

    task automatic test_probe_decode();
        build_frame(FIRE_MSG, BUS_OK);
        set_probes(8'h01, 8'h0A, 8'h13, 8'h1C);
        seal_frame();
        send_frame(1'b0, FRAME_BYTES, 0);
        build_frame(FIRE_MSG, BUS_OK);
        set_probes(8'h25, 8'h2E, 8'h3F, 8'h00);
        seal_frame();
        send_frame(1'b1, FRAME_BYTES, 0);
        build_frame(FIRE_MSG, BUS_OK);
        set_probes(8'hC1, 8'h4A, 8'h93, 8'h00);
        seal_frame();
        send_frame(1'b0, FRAME_BYTES, 0);
    endtask

    task automatic test_frame_errors();
        build_frame(FIRE_MSG, BUS_OK);
        frame_buf[0] = 8'h55;
        seal_frame();
        send_frame(1'b0, FRAME_BYTES, 0);
        // header wins over a bad length
        build_frame(FIRE_MSG, BUS_OK);
        frame_buf[1] = 8'hAB;
        frame_buf[2] = 8'h00;
        seal_frame();
        send_frame(1'b1, FRAME_BYTES, 0);
        build_frame(FIRE_MSG, BUS_OK);
        frame_buf[2] = 8'h2B;
        seal_frame();
        send_frame(1'b0, FRAME_BYTES, 0);
        build_frame(FIRE_MSG, BUS_OK);
        frame_buf[3] = 8'h01;
        seal_frame();
        send_frame(1'b1, FRAME_BYTES, 0);
        build_frame(FIRE_MSG, BUS_OK);
        seal_frame();
        frame_buf[FRAME_BYTES-1] ^= 8'h80;
        send_frame(1'b0, FRAME_BYTES, 0);
        build_frame(8'h00, BUS_OK);
        seal_frame();
        send_frame(1'b1, FRAME_BYTES, 0);
        build_frame(8'hFF, BUS_OK);
        seal_frame();
        send_frame(1'b0, FRAME_BYTES, 0);
        build_frame(FIRE_MSG, BUS_OPEN);
        seal_frame();
        send_frame(1'b1, FRAME_BYTES, 0);
        build_frame(FIRE_MSG, BUS_SHORT);
        seal_frame();
        send_frame(1'b0, FRAME_BYTES, 0);
        build_frame(FIRE_MSG, 8'h80);
        seal_frame();
        send_frame(1'b1, FRAME_BYTES, 0);
    endtask

    task automatic test_framing();
        send_item(1'b0, 1'b0, HDR_BYTE, 1'b0);
        send_item(1'b0, 1'b1, 8'hFF, 1'b0);
        build_frame(FIRE_MSG, BUS_OK);
        seal_frame();
        send_frame(1'b0, 20, 0);
        build_frame(FIRE_MSG, BUS_OK);
        seal_frame();
        send_frame(1'b1, FRAME_BYTES - 1, 0);
        build_frame(FIRE_MSG, BUS_OK);
        seal_frame();
        send_frame(1'b0, FRAME_BYTES, 30);
    endtask

    task automatic test_channel_map();
        set_reg(REG_CHANNEL_MAP, 16'hF1A0);
        build_frame(FIRE_MSG, BUS_OK);
        set_probes(8'h21, 8'h22, 8'h23, 8'h24);
        seal_frame();
        send_frame(1'b1, FRAME_BYTES, 0);
        set_reg(REG_CHANNEL_MAP, 16'hFFFF);
        build_frame(FIRE_MSG, BUS_OK);
        set_probes(8'hE4, 8'h00, 8'h00, 8'h00);
        seal_frame();
        send_frame(1'b0, FRAME_BYTES, 0);
        build_frame(FIRE_MSG, BUS_OK);
        set_probes(8'h09, 8'h00, 8'h3F, 8'h1A);
        seal_frame();
        send_frame(1'b1, FRAME_BYTES, 0);
        set_reg(REG_CHANNEL_MAP, 16'($urandom));
    endtask

    task automatic test_silence();
        set_reg(REG_TIMEOUT, 16'd31);
        repeat (40) send_tick();
        set_reg(REG_TIMEOUT, 16'd1);
        repeat (6) send_tick();
        build_frame(FIRE_MSG, BUS_OK);
        seal_frame();
        send_frame(1'b1, FRAME_BYTES, 0);
        repeat (6) send_tick();
        set_reg(REG_TIMEOUT, 16'd15);
        repeat (20) send_tick();
    endtask

    task automatic test_random();
        int start_items;
        int r;
        start_items   = items_sent;
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if (items_sent - start_items > QUIET_ITEMS) begin
                src_idle_on   = 1'b1;
                sink_stall_on = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 65) begin
                rand_frame(FRAME_BYTES, 3);
            end else if (r < 75) begin
                repeat ($urandom_range(1, 20)) send_tick();
            end else if (r < 85) begin
                rand_frame($urandom_range(1, FRAME_BYTES - 1), 0);
            end else if (r < 93) begin
                repeat ($urandom_range(1, 6))
                    send_item(1'b0, 1'($urandom_range(1)), 8'($urandom),
                              $urandom_range(9) == 0);
            end else if (r < 97) begin
                wait_drained(0);
            end else if ($urandom_range(1) == 0) begin
                r = $urandom_range(2);
                set_reg(REG_CHANNEL_MAP, (r == 0) ? 16'h0000 :
                                         (r == 1) ? 16'hFFFF : 16'($urandom));
            end else begin
                r = $urandom_range(2);
                set_reg(REG_TIMEOUT, (r == 0) ? 16'd1 :
                                     (r == 1) ? 16'd31 : 16'($urandom_range(1, 31)));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_probe_decode();
        test_frame_errors();
        test_framing();
        test_channel_map();
        test_silence();
        test_random();
        wait_drained(10);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/fpfd_pkg.sv
rtl/fire_probe_frame_decoder_top.sv
bench/tb_fire_probe_frame_decoder_top.sv
